// File: design/p2g_pkg.sv
`default_nettype none

package p2g_pkg;

    localparam int GRID_WIDTH_DEFAULT  = 51;
    localparam int GRID_HEIGHT_DEFAULT = 25;
    localparam int CENTER_COL_DEFAULT  = 25;
    localparam int CENTER_ROW_DEFAULT  = 12;

    localparam int DIST_W  = 16;
    localparam int ANGLE_W = 16;
    localparam int QUAL_W  = 8;
    localparam int DEG_W   = 9;
    localparam int MAG_IDX_W = 7;
    localparam int MM_W    = 14;
    localparam int MIN_W   = 16;
    localparam int ROW_W   = 5;
    localparam int COL_W   = 6;
    localparam int INDEX_W = 11;
    localparam int POS_W   = 10;
    localparam int CELL_W  = 8;
    localparam int RECIP_W = 27;
    localparam int PROD_W  = DIST_W + RECIP_W;
    localparam int COL_OFF_W = 8;
    localparam int ROW_OFF_W = 7;

    localparam longint COL_DIV     = 400000;
    localparam int     COL_SHIFT   = 35;
    localparam int     ROW_SHIFT   = 36;
    localparam int     ROUND_BIAS  = 50;
    localparam int     CLAMP_CDEG  = 36000;
    localparam int     DEG_MAX     = 359;
    localparam int     DEG_FULL    = 360;
    localparam int     DEG_QUARTER = 90;
    localparam int     DEG_HALF    = 180;
    localparam int     DEG_3QTR    = 270;
    localparam int     DEG_RECIP   = 41944;
    localparam int     DEG_SHIFT   = 22;
    localparam logic [MIN_W-1:0] MIN_RESET = '1;

    typedef logic [9:0] quarter_sine_t [0:90];
    typedef logic [RECIP_W-1:0] recip_table_t [0:90];

    localparam quarter_sine_t QUARTER_SINE = '{
        10'd0,   10'd17,  10'd35,  10'd52,  10'd70,  10'd87,  10'd105, 10'd122,
        10'd139, 10'd156, 10'd174, 10'd191, 10'd208, 10'd225, 10'd242, 10'd259,
        10'd276, 10'd292, 10'd309, 10'd326, 10'd342, 10'd358, 10'd375, 10'd391,
        10'd407, 10'd423, 10'd438, 10'd454, 10'd469, 10'd485, 10'd500, 10'd515,
        10'd530, 10'd545, 10'd559, 10'd574, 10'd588, 10'd602, 10'd616, 10'd629,
        10'd643, 10'd656, 10'd669, 10'd682, 10'd695, 10'd707, 10'd719, 10'd731,
        10'd743, 10'd755, 10'd766, 10'd777, 10'd788, 10'd799, 10'd809, 10'd819,
        10'd829, 10'd839, 10'd848, 10'd857, 10'd866, 10'd875, 10'd883, 10'd891,
        10'd899, 10'd906, 10'd914, 10'd921, 10'd927, 10'd934, 10'd940, 10'd946,
        10'd951, 10'd956, 10'd961, 10'd966, 10'd970, 10'd974, 10'd978, 10'd982,
        10'd985, 10'd988, 10'd990, 10'd993, 10'd995, 10'd996, 10'd998, 10'd999,
        10'd999, 10'd1000, 10'd1000
    };

    // ceil(sin * 2^35 / 400000): exact floor quotient for any 16-bit distance
    function automatic recip_table_t build_recip_table();
        recip_table_t r;
        longint unsigned num;
        for (int i = 0; i <= DEG_QUARTER; i++)
        begin
            num  = (longint'(QUARTER_SINE[i]) << COL_SHIFT) + COL_DIV - 1;
            r[i] = RECIP_W'(num / COL_DIV);
        end
        return r;
    endfunction

    localparam recip_table_t RECIP_TABLE = build_recip_table();

    typedef struct packed {
        logic                 neg;
        logic [MAG_IDX_W-1:0] idx;
    } fold_t;

    function automatic fold_t fold_degree(input logic [DEG_W-1:0] d);
        fold_t f;
        f.neg = 1'b0;
        if (d <= DEG_W'(DEG_QUARTER))
        begin
            f.idx = d[MAG_IDX_W-1:0];
        end
        else if (d <= DEG_W'(DEG_HALF))
        begin
            f.idx = MAG_IDX_W'(DEG_W'(DEG_HALF) - d);
        end
        else if (d <= DEG_W'(DEG_3QTR))
        begin
            f.neg = 1'b1;
            f.idx = MAG_IDX_W'(d - DEG_W'(DEG_HALF));
        end
        else
        begin
            f.neg = 1'b1;
            f.idx = MAG_IDX_W'(DEG_W'(DEG_FULL) - d);
        end
        return f;
    endfunction

    typedef struct packed {
        logic               plot;
        logic [ROW_W-1:0]   row;
        logic [COL_W-1:0]   col;
        logic [INDEX_W-1:0] index;
    } cell_result_t;

endpackage

`default_nettype wire

// File: design/p2g_cell_calc.sv
`default_nettype none

module p2g_cell_calc #(
    parameter int GRID_WIDTH  = p2g_pkg::GRID_WIDTH_DEFAULT,
    parameter int GRID_HEIGHT = p2g_pkg::GRID_HEIGHT_DEFAULT,
    parameter int CENTER_COL  = p2g_pkg::CENTER_COL_DEFAULT,
    parameter int CENTER_ROW  = p2g_pkg::CENTER_ROW_DEFAULT
) (
    input  wire logic [p2g_pkg::DIST_W-1:0] dist_qmm,
    input  wire logic [p2g_pkg::DEG_W-1:0]  deg,
    input  wire logic                       accepted,
    output p2g_pkg::cell_result_t           mapped
);
    import p2g_pkg::*;

    logic [DEG_W:0]         cos_sum;
    logic [DEG_W-1:0]       cos_deg;
    fold_t                  sin_fold;
    fold_t                  cos_fold;
    logic [RECIP_W-1:0]     sin_recip;
    logic [RECIP_W-1:0]     cos_recip;
    logic [PROD_W-1:0]      col_prod;
    logic [PROD_W-1:0]      row_prod;
    logic [COL_OFF_W-1:0]   col_off;
    logic [ROW_OFF_W-1:0]   row_off;
    logic signed [POS_W-1:0] col_pos;
    logic signed [POS_W-1:0] row_pos;
    logic                   in_grid;
    logic [CELL_W-1:0]      row_cell;
    logic [CELL_W-1:0]      col_cell;
    logic [15:0]            index_full;

    always_comb
    begin
        cos_sum = (DEG_W+1)'(deg) + (DEG_W+1)'(DEG_QUARTER);
        if (cos_sum >= (DEG_W+1)'(DEG_FULL))
        begin
            cos_deg = DEG_W'(cos_sum - (DEG_W+1)'(DEG_FULL));
        end
        else
        begin
            cos_deg = cos_sum[DEG_W-1:0];
        end
        sin_fold  = fold_degree(deg);
        cos_fold  = fold_degree(cos_deg);
        sin_recip = RECIP_TABLE[sin_fold.idx];
        cos_recip = RECIP_TABLE[cos_fold.idx];
    end

    assign col_prod = PROD_W'(dist_qmm) * PROD_W'(cos_recip);
    assign row_prod = PROD_W'(dist_qmm) * PROD_W'(sin_recip);
    assign col_off  = col_prod[COL_SHIFT +: COL_OFF_W];
    assign row_off  = row_prod[ROW_SHIFT +: ROW_OFF_W];

    always_comb
    begin
        if (cos_fold.neg)
        begin
            col_pos = signed'(POS_W'(CENTER_COL)) - signed'(POS_W'(col_off));
        end
        else
        begin
            col_pos = signed'(POS_W'(CENTER_COL)) + signed'(POS_W'(col_off));
        end
        if (sin_fold.neg)
        begin
            row_pos = signed'(POS_W'(CENTER_ROW)) + signed'(POS_W'(row_off));
        end
        else
        begin
            row_pos = signed'(POS_W'(CENTER_ROW)) - signed'(POS_W'(row_off));
        end
        in_grid = accepted
               && (row_pos >= 0) && (row_pos < signed'(POS_W'(GRID_HEIGHT)))
               && (col_pos >= 0) && (col_pos < signed'(POS_W'(GRID_WIDTH)));
        row_cell   = row_pos[CELL_W-1:0];
        col_cell   = col_pos[CELL_W-1:0];
        index_full = 16'(row_cell) * 16'(GRID_WIDTH) + 16'(col_cell);

        mapped.plot = in_grid;
        if (in_grid)
        begin
            mapped.row   = row_cell[ROW_W-1:0];
            mapped.col   = col_cell[COL_W-1:0];
            mapped.index = index_full[INDEX_W-1:0];
        end
        else
        begin
            mapped.row   = '0;
            mapped.col   = '0;
            mapped.index = '0;
        end
    end

endmodule

`default_nettype wire

// File: design/polar_to_grid_cell_mapper.sv
`default_nettype none

// Maps one lidar sample per transaction to a cell of a top-down grid and
// reports the running range minimum and maximum of the current scan. Each
// sample passes an input register, where the bearing is rounded to whole
// degrees, and then a result register, where the sine lookup, the two
// distance multiplies and the bounds check are resolved; a new sample is
// taken every cycle while out_ready stays high, and its result is held in
// the result register with out_valid high until out_ready takes it. Rejected
// samples (zero quality or zero distance) still produce a transaction with
// plot_valid low.

module polar_to_grid_cell_mapper #(
    parameter int GRID_WIDTH  = p2g_pkg::GRID_WIDTH_DEFAULT,
    parameter int GRID_HEIGHT = p2g_pkg::GRID_HEIGHT_DEFAULT,
    parameter int CENTER_COL  = p2g_pkg::CENTER_COL_DEFAULT,
    parameter int CENTER_ROW  = p2g_pkg::CENTER_ROW_DEFAULT
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [p2g_pkg::DIST_W-1:0]   distance_qmm,
    input  wire logic [p2g_pkg::ANGLE_W-1:0]  angle_centideg,
    input  wire logic [p2g_pkg::QUAL_W-1:0]   sample_quality,
    input  wire logic                         scan_start,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic                              sample_accepted,
    output logic                              plot_valid,
    output logic [p2g_pkg::ROW_W-1:0]         grid_row,
    output logic [p2g_pkg::COL_W-1:0]         grid_col,
    output logic [p2g_pkg::INDEX_W-1:0]       cell_index,
    output logic [p2g_pkg::MIN_W-1:0]         range_min_mm,
    output logic [p2g_pkg::MM_W-1:0]          range_max_mm,
    output logic                              range_valid
);
    import p2g_pkg::*;

    logic                s1_valid_reg;
    logic                s1_valid_next;
    logic [DIST_W-1:0]   s1_dist_reg;
    logic [DEG_W-1:0]    s1_deg_reg;
    logic [DEG_W-1:0]    s1_deg_next;
    logic                s1_accept_reg;
    logic                s1_start_reg;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic                in_xfer;
    logic                s1_advance;

    logic [ANGLE_W:0]    angle_sum;
    logic [31:0]         deg_prod;

    cell_result_t        cell_next;
    cell_result_t        cell_reg;
    logic                accepted_reg;

    logic [MIN_W-1:0]    min_reg;
    logic [MIN_W-1:0]    min_next;
    logic [MM_W-1:0]     max_reg;
    logic [MM_W-1:0]     max_next;
    logic [MIN_W-1:0]    min_base;
    logic [MM_W-1:0]     max_base;
    logic [MM_W-1:0]     s1_mm;

    assign s1_advance = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready   = !s1_valid_reg || !out_valid_reg || out_ready;
    assign in_xfer    = in_valid && in_ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_xfer)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_advance)
        begin
            s1_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (s1_advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // round to whole degrees: (angle + 50) / 100 by reciprocal, clamp to 359
    always_comb
    begin
        angle_sum = (ANGLE_W+1)'(angle_centideg) + (ANGLE_W+1)'(ROUND_BIAS);
        deg_prod  = 32'(angle_sum[ANGLE_W-1:0]) * 32'(DEG_RECIP);
        if (angle_sum >= (ANGLE_W+1)'(CLAMP_CDEG))
        begin
            s1_deg_next = DEG_W'(DEG_MAX);
        end
        else
        begin
            s1_deg_next = deg_prod[DEG_SHIFT +: DEG_W];
        end
    end

    p2g_cell_calc #(
        .GRID_WIDTH  (GRID_WIDTH),
        .GRID_HEIGHT (GRID_HEIGHT),
        .CENTER_COL  (CENTER_COL),
        .CENTER_ROW  (CENTER_ROW)
    ) u_cell_calc (
        .dist_qmm (s1_dist_reg),
        .deg      (s1_deg_reg),
        .accepted (s1_accept_reg),
        .mapped   (cell_next)
    );

    always_comb
    begin
        s1_mm    = s1_dist_reg[DIST_W-1:2];
        min_base = s1_start_reg ? MIN_RESET : min_reg;
        max_base = s1_start_reg ? '0 : max_reg;
        min_next = min_base;
        max_next = max_base;
        if (s1_accept_reg && (MIN_W'(s1_mm) < min_base))
        begin
            min_next = MIN_W'(s1_mm);
        end
        if (s1_accept_reg && (s1_mm > max_base))
        begin
            max_next = s1_mm;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            min_reg       <= MIN_RESET;
            max_reg       <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (s1_advance)
            begin
                min_reg <= min_next;
                max_reg <= max_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_dist_reg   <= distance_qmm;
            s1_deg_reg    <= s1_deg_next;
            s1_accept_reg <= (sample_quality != '0) && (distance_qmm != '0);
            s1_start_reg  <= scan_start;
        end
        if (s1_advance)
        begin
            cell_reg     <= cell_next;
            accepted_reg <= s1_accept_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign sample_accepted = accepted_reg;
    assign plot_valid      = cell_reg.plot;
    assign grid_row        = cell_reg.row;
    assign grid_col        = cell_reg.col;
    assign cell_index      = cell_reg.index;
    assign range_min_mm    = min_reg;
    assign range_max_mm    = max_reg;
    assign range_valid     = (max_reg != '0);

endmodule

`default_nettype wire
